[design/dqsd_pkg.sv]
// ----------------------------------------------------------------------------
// DQPSK soft demapper package
// Shared constants and the payload types of the input and result channels.
// ----------------------------------------------------------------------------
package dqsd_pkg;

  localparam int unsigned FFT_SIZE       = 2048;
  localparam int unsigned USED_CARRIERS  = 1536;
  localparam int unsigned SAMPLE_WIDTH   = 16;
  localparam int unsigned GAIN_FRAC_BITS = 32;
  localparam int unsigned GAIN_WIDTH     = 24;
  localparam int unsigned INDEX_WIDTH    = 11;
  localparam int unsigned SOFT_WIDTH     = 8;

  localparam int unsigned EDGE_BINS  = (FFT_SIZE - USED_CARRIERS) / 2;
  localparam int unsigned LAST_USED  = USED_CARRIERS + EDGE_BINS;
  localparam int unsigned CENTRE_BIN = FFT_SIZE / 2;

  // Soft byte midpoint and ceiling.
  localparam int SOFT_MID = 128;
  localparam int SOFT_MAX = 255;

  typedef struct packed {
    logic signed [SAMPLE_WIDTH-1:0] bin_real;
    logic signed [SAMPLE_WIDTH-1:0] bin_imag;
    logic [INDEX_WIDTH-1:0]         bin_index;
    logic                           reference_symbol;
  } dqsd_in_t;

  typedef struct packed {
    logic [INDEX_WIDTH-1:0] carrier_number;
    logic [SOFT_WIDTH-1:0]  soft_real;
    logic [SOFT_WIDTH-1:0]  soft_imag;
  } dqsd_out_t;

endpackage

[design/dqsd_ram.sv]
// ----------------------------------------------------------------------------
// Generic single-write, single-read RAM
// One write port and one read port; the read data is registered and returns
// the contents from before a write to the same address in the same cycle.
// ----------------------------------------------------------------------------
module dqsd_ram #(
  parameter int unsigned Width = 32,
  parameter int unsigned Depth = 2048
) (
  input  logic                     clk_i,
  input  logic                     we_i,
  input  logic [$clog2(Depth)-1:0] waddr_i,
  input  logic [Width-1:0]         wdata_i,
  input  logic                     re_i,
  input  logic [$clog2(Depth)-1:0] raddr_i,
  output logic [Width-1:0]         rdata_o
);

  logic [Width-1:0] mem_q [Depth];
  logic [Width-1:0] rdata_q;

  always_ff @(posedge clk_i) begin
    if (we_i) begin
      mem_q[waddr_i] <= wdata_i;
    end
    if (re_i) begin
      rdata_q <= mem_q[raddr_i];
    end
  end

  assign rdata_o = rdata_q;

endmodule

[design/dqpsk_soft_demapper_core.sv]
// ----------------------------------------------------------------------------
// DQPSK soft demapper core
// Differential demapping of centred FFT bins into two soft bytes per carrier.
// ----------------------------------------------------------------------------
// The core takes one FFT bin per clock while in_stall_o is low. A result
// passes through the registers s1 to s4 and then the output register.
// Each bin reads the previous symbol's bin at the
// same index from a 2048-entry RAM and writes the new bin back in the same
// cycle, so the one read port and one write port of that RAM set the rate of
// one bin per clock. Used carriers of a non-reference symbol give one result
// (carrier number and two soft bytes); reference symbols, edge bins and the
// centre bin only update the RAM. The RAM is not cleared at reset: the first
// symbol after reset must be a reference symbol. The gain register may only
// be written while the core is idle.
module dqpsk_soft_demapper_core (
  input  logic                                clk_i,
  input  logic                                rst_ni,
  input  logic                                in_valid_i,
  output logic                                in_stall_o,
  input  dqsd_pkg::dqsd_in_t                  in_data_i,
  output logic                                out_valid_o,
  input  logic                                out_stall_i,
  output dqsd_pkg::dqsd_out_t                 out_data_o,
  input  logic                                cfg_we_i,
  input  logic [dqsd_pkg::GAIN_WIDTH-1:0]     cfg_data_i
);

  import dqsd_pkg::*;

  localparam int unsigned PairW = 2 * SAMPLE_WIDTH;
  localparam int unsigned SumW  = PairW + 2;
  localparam int unsigned ProdW = SumW + GAIN_WIDTH + 1;

  localparam logic signed [ProdW-1:0] LowLimit  = -ProdW'(SOFT_MID);
  localparam logic signed [ProdW-1:0] HighLimit = ProdW'(SOFT_MID - 1);

  // Scaled value to soft byte: clamp to -128..127, then add 128.
  function automatic logic [SOFT_WIDTH-1:0] soft_byte(input logic signed [ProdW-1:0] v);
    logic [SOFT_WIDTH-1:0] b;
    if (v < LowLimit) begin
      b = '0;
    end else if (v > HighLimit) begin
      b = SOFT_WIDTH'(SOFT_MAX);
    end else begin
      b = v[SOFT_WIDTH-1:0] ^ SOFT_WIDTH'(SOFT_MID);
    end
    return b;
  endfunction

  logic [GAIN_WIDTH-1:0] gain_q;

  logic accept;
  logic emit;
  logic [INDEX_WIDTH-1:0] carrier;

  logic [PairW-1:0] prev_word;
  logic signed [SAMPLE_WIDTH-1:0] prev_real, prev_imag;

  logic s1_valid_q, s2_valid_q, s3_valid_q, s4_valid_q, out_valid_q;
  logic s1_ready, s2_ready, s3_ready, s4_ready, out_ready;

  logic [INDEX_WIDTH-1:0] s1_carrier_q, s2_carrier_q, s3_carrier_q, s4_carrier_q;
  logic signed [SAMPLE_WIDTH-1:0] s1_real_q, s1_imag_q;
  logic signed [PairW-1:0] s2_rr_q, s2_ii_q, s2_ri_q, s2_ir_q;
  logic signed [SumW-1:0]  s3_re_d, s3_im_d, s3_re_q, s3_im_q;
  logic signed [ProdW-1:0] s4_re_q, s4_im_q, re_shift, im_shift;
  dqsd_out_t out_data_q;

  assign accept = in_valid_i && !in_stall_o;

  assign emit = !in_data_i.reference_symbol
             && (in_data_i.bin_index >= INDEX_WIDTH'(EDGE_BINS))
             && (in_data_i.bin_index <= INDEX_WIDTH'(LAST_USED))
             && (in_data_i.bin_index != INDEX_WIDTH'(CENTRE_BIN));

  // Carriers above the centre skip the unused centre bin.
  assign carrier = in_data_i.bin_index - INDEX_WIDTH'(EDGE_BINS)
                 - ((in_data_i.bin_index > INDEX_WIDTH'(CENTRE_BIN)) ?
                    INDEX_WIDTH'(1) : INDEX_WIDTH'(0));

  // The RAM returns the old contents on a same-address write, so the read and
  // the write-back of one bin share the accept cycle and the next bin at that
  // index already sees the new value.
  dqsd_ram #(
    .Width (PairW),
    .Depth (FFT_SIZE)
  ) u_prev_ram (
    .clk_i   (clk_i),
    .we_i    (accept),
    .waddr_i (in_data_i.bin_index),
    .wdata_i ({in_data_i.bin_real, in_data_i.bin_imag}),
    .re_i    (accept),
    .raddr_i (in_data_i.bin_index),
    .rdata_o (prev_word)
  );

  assign prev_real = prev_word[PairW-1:SAMPLE_WIDTH];
  assign prev_imag = prev_word[SAMPLE_WIDTH-1:0];

  assign out_ready  = !out_valid_q || !out_stall_i;
  assign s4_ready   = !s4_valid_q || out_ready;
  assign s3_ready   = !s3_valid_q || s4_ready;
  assign s2_ready   = !s2_valid_q || s3_ready;
  assign s1_ready   = !s1_valid_q || s2_ready;
  assign in_stall_o = !s1_ready;

  assign s3_re_d = -(SumW'(s2_rr_q) + SumW'(s2_ii_q));
  assign s3_im_d = SumW'(s2_ri_q) - SumW'(s2_ir_q);

  // Arithmetic shift gives the floor for either sign.
  assign re_shift = s4_re_q >>> GAIN_FRAC_BITS;
  assign im_shift = s4_im_q >>> GAIN_FRAC_BITS;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      gain_q      <= '0;
      s1_valid_q  <= 1'b0;
      s2_valid_q  <= 1'b0;
      s3_valid_q  <= 1'b0;
      s4_valid_q  <= 1'b0;
      out_valid_q <= 1'b0;
    end else begin
      if (cfg_we_i) begin
        gain_q <= cfg_data_i;
      end
      if (s1_ready) begin
        s1_valid_q <= accept && emit;
      end
      if (s2_ready) begin
        s2_valid_q <= s1_valid_q;
      end
      if (s3_ready) begin
        s3_valid_q <= s2_valid_q;
      end
      if (s4_ready) begin
        s4_valid_q <= s3_valid_q;
      end
      if (out_ready) begin
        out_valid_q <= s4_valid_q;
      end
    end
  end

  always_ff @(posedge clk_i) begin
    if (accept) begin
      s1_carrier_q <= carrier;
      s1_real_q    <= in_data_i.bin_real;
      s1_imag_q    <= in_data_i.bin_imag;
    end
    if (s2_ready && s1_valid_q) begin
      s2_carrier_q <= s1_carrier_q;
      s2_rr_q      <= PairW'(s1_real_q) * PairW'(prev_real);
      s2_ii_q      <= PairW'(s1_imag_q) * PairW'(prev_imag);
      s2_ri_q      <= PairW'(s1_real_q) * PairW'(prev_imag);
      s2_ir_q      <= PairW'(s1_imag_q) * PairW'(prev_real);
    end
    if (s3_ready && s2_valid_q) begin
      s3_carrier_q <= s2_carrier_q;
      s3_re_q      <= s3_re_d;
      s3_im_q      <= s3_im_d;
    end
    if (s4_ready && s3_valid_q) begin
      s4_carrier_q <= s3_carrier_q;
      s4_re_q      <= ProdW'(s3_re_q) * $signed(ProdW'({1'b0, gain_q}));
      s4_im_q      <= ProdW'(s3_im_q) * $signed(ProdW'({1'b0, gain_q}));
    end
    if (out_ready && s4_valid_q) begin
      out_data_q.carrier_number <= s4_carrier_q;
      out_data_q.soft_real      <= soft_byte(re_shift);
      out_data_q.soft_imag      <= soft_byte(im_shift);
    end
  end

  assign out_valid_o = out_valid_q;
  assign out_data_o  = out_data_q;

endmodule

[design/dqsd_checker.sv]
// ----------------------------------------------------------------------------
// DQPSK soft demapper port checker
// Watches the core's ports for handshake and result-range violations.
// ----------------------------------------------------------------------------
module dqsd_checker (
  input logic                                clk_i,
  input logic                                rst_ni,
  input logic                                in_valid_i,
  input logic                                in_stall_o,
  input dqsd_pkg::dqsd_in_t                  in_data_i,
  input logic                                out_valid_o,
  input logic                                out_stall_i,
  input dqsd_pkg::dqsd_out_t                 out_data_o
);

  import dqsd_pkg::*;

  // A stalled input transaction stays offered and unchanged.
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    in_valid_i && in_stall_o |=> in_valid_i && $stable(in_data_i))
    else $error("stalled input changed");

  // A stalled result stays offered.
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_o && out_stall_i |=> out_valid_o)
    else $error("result withdrawn while stalled");

  assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_o && out_stall_i |=> $stable(out_data_o))
    else $error("stalled result changed");

  // With the output register empty the whole pipeline can move.
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    !out_valid_o |-> !in_stall_o)
    else $error("input stalled while output register is empty");

  assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_o |-> out_data_o.carrier_number < INDEX_WIDTH'(USED_CARRIERS))
    else $error("carrier number out of range");

endmodule

bind dqpsk_soft_demapper_core dqsd_checker u_dqsd_checker (
  .clk_i       (clk_i),
  .rst_ni      (rst_ni),
  .in_valid_i  (in_valid_i),
  .in_stall_o  (in_stall_o),
  .in_data_i   (in_data_i),
  .out_valid_o (out_valid_o),
  .out_stall_i (out_stall_i),
  .out_data_o  (out_data_o)
);
